FILE: rtl/pfq_pkg.sv
// shared types and codes for the priority queue with duplicate rejection
package pfq_pkg;

   typedef enum logic [1:0] {
      FUNC_ENQ      = 2'd0,
      FUNC_POP      = 2'd1,
      FUNC_REMOVE   = 2'd2,
      FUNC_CONTAINS = 2'd3
   } func_type;

   typedef enum logic [3:0] {
      ST_QUEUED     = 4'd0,
      ST_DUPLICATE  = 4'd1,
      ST_FULL       = 4'd2,
      ST_DISPATCHED = 4'd3,
      ST_EMPTY      = 4'd4,
      ST_REMOVED    = 4'd5,
      ST_NOT_FOUND  = 4'd6,
      ST_PRESENT    = 4'd7,
      ST_ABSENT     = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DONE
   } back_state_type;

   localparam int TASK_ID_W = 16;
   localparam int PRIO_W    = 8;
   localparam int SEQ_W     = 32;
   localparam int PAYLOAD_W = 32;
   localparam int COUNT_W   = 5;

   // one request as it travels from the front to the back
   typedef struct packed {
      func_type                 func;
      logic [TASK_ID_W-1:0]     task_id;
      logic signed [PRIO_W-1:0] prio;
      logic [PAYLOAD_W-1:0]     payload;
   } req_type;

endpackage

FILE: rtl/pfq_front.sv
// request capture and two-entry queue toward the execution side
module pfq_front import pfq_pkg::*; #(
   parameter int ID_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_func,
   input  logic [TASK_ID_W-1:0]     req_task_id,
   input  logic signed [PRIO_W-1:0] req_prio,
   input  logic [PAYLOAD_W-1:0]     req_payload,
   output logic                     q_valid,
   output req_type                  q_data,
   input  logic                     q_pop,
   input  logic                     back_busy
);

   req_type    slot_ff [2];
   req_type    incoming;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in;
   logic       push;

   // one request in flight at a time: the back side owns the queue state
   assign busy = (cnt_ff != 2'd0) || back_busy;
   assign push = start && !busy;

   always_comb begin
      incoming = '0;
      incoming.func = func_type'(req_func);
      if (ID_BITS < TASK_ID_W) begin
         incoming.task_id = req_task_id & TASK_ID_W'((17'd1 << ID_BITS) - 17'd1);
      end else begin
         incoming.task_id = req_task_id;
      end
      incoming.prio = req_prio;
      incoming.payload = req_payload;
   end

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
      rd_in = rd_ff ^ q_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[rd_ff ^ cnt_ff[0]] <= incoming;
      end
   end

   assign q_valid = cnt_ff != 2'd0;
   assign q_data = slot_ff[rd_ff];

endmodule

FILE: rtl/pfq_back.sv
// entry store, associative id match and sequential best-entry scan
module pfq_back import pfq_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  req_type                  q_data,
   output logic                     q_pop,
   output logic                     back_busy,
   output logic                     rsp_valid,
   output logic                     rsp_ok,
   output logic [3:0]               rsp_status,
   output logic [TASK_ID_W-1:0]     rsp_out_id,
   output logic signed [PRIO_W-1:0] rsp_out_prio,
   output logic [SEQ_W-1:0]         rsp_out_seq,
   output logic [PAYLOAD_W-1:0]     rsp_out_payload,
   output logic [COUNT_W-1:0]       rsp_count,
   output logic                     rsp_is_empty
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DEPTH-1:0]         valid_ff, valid_in;
   logic [TASK_ID_W-1:0]     id_ff [DEPTH];
   logic signed [PRIO_W-1:0] prio_ff [DEPTH];
   logic [SEQ_W-1:0]         seq_ff [DEPTH];
   logic [PAYLOAD_W-1:0]     pay_ff [DEPTH];
   logic [SEQ_W-1:0]         next_seq_ff, next_seq_in;
   logic [CNT_W-1:0]         held_ff, held_in;

   back_state_type           state_ff, state_in;
   req_type                  cur_ff, cur_in;
   logic [IDX_W-1:0]         scan_ff, scan_in;
   logic                     best_v_ff, best_v_in;
   logic [IDX_W-1:0]         best_ff, best_in;
   logic signed [PRIO_W-1:0] best_prio_ff, best_prio_in;
   logic [SEQ_W-1:0]         best_seq_ff, best_seq_in;

   logic                     o_valid_ff, o_valid_in;
   logic                     o_ok_ff, o_ok_in;
   status_type               o_status_ff, o_status_in;
   logic [TASK_ID_W-1:0]     o_id_ff, o_id_in;
   logic signed [PRIO_W-1:0] o_prio_ff, o_prio_in;
   logic [SEQ_W-1:0]         o_seq_ff, o_seq_in;
   logic [PAYLOAD_W-1:0]     o_pay_ff, o_pay_in;

   logic [DEPTH-1:0]         hit;
   logic                     hit_any, free_any;
   logic [IDX_W-1:0]         hit_idx, free_idx;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_idx;
   logic                     better;

   always_comb begin
      hit_idx = '0;
      free_idx = '0;
      free_any = 1'b0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         hit[i] = valid_ff[i] && (id_ff[i] == cur_ff.task_id);
         if (hit[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
            free_any = 1'b1;
         end
      end
      hit_any = |hit;
   end

   // strict compare keeps the lower slot on exact ties
   assign better = valid_ff[scan_ff] && (!best_v_ff || (prio_ff[scan_ff] > best_prio_ff) ||
                   ((prio_ff[scan_ff] == best_prio_ff) && (seq_ff[scan_ff] < best_seq_ff)));

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      scan_in = scan_ff;
      best_v_in = best_v_ff;
      best_in = best_ff;
      best_prio_in = best_prio_ff;
      best_seq_in = best_seq_ff;
      valid_in = valid_ff;
      next_seq_in = next_seq_ff;
      held_in = held_ff;
      q_pop = 1'b0;
      wr_en = 1'b0;
      wr_idx = free_idx;
      o_valid_in = 1'b0;
      o_ok_in = 1'b0;
      o_status_in = ST_QUEUED;
      o_id_in = '0;
      o_prio_in = '0;
      o_seq_in = '0;
      o_pay_in = '0;
      case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               cur_in = q_data;
               scan_in = '0;
               best_v_in = 1'b0;
               state_in = (q_data.func == FUNC_POP) ? BK_SCAN : BK_DONE;
            end
         end
         BK_SCAN: begin
            if (better) begin
               best_v_in = 1'b1;
               best_in = scan_ff;
               best_prio_in = prio_ff[scan_ff];
               best_seq_in = seq_ff[scan_ff];
            end
            scan_in = scan_ff + 1'b1;
            if (scan_ff == IDX_W'(DEPTH - 1)) begin
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            o_valid_in = 1'b1;
            state_in = BK_IDLE;
            case (cur_ff.func)
               FUNC_ENQ: begin
                  if (hit_any) begin
                     o_status_in = ST_DUPLICATE;
                  end else if (!free_any) begin
                     o_status_in = ST_FULL;
                  end else begin
                     wr_en = 1'b1;
                     valid_in[free_idx] = 1'b1;
                     next_seq_in = next_seq_ff + 1'b1;
                     held_in = held_ff + 1'b1;
                     o_ok_in = 1'b1;
                     o_status_in = ST_QUEUED;
                  end
               end
               FUNC_POP: begin
                  if (!best_v_ff) begin
                     o_status_in = ST_EMPTY;
                  end else begin
                     valid_in[best_ff] = 1'b0;
                     held_in = held_ff - 1'b1;
                     o_ok_in = 1'b1;
                     o_status_in = ST_DISPATCHED;
                     o_id_in = id_ff[best_ff];
                     o_prio_in = prio_ff[best_ff];
                     o_seq_in = seq_ff[best_ff];
                     o_pay_in = pay_ff[best_ff];
                  end
               end
               FUNC_REMOVE: begin
                  if (hit_any) begin
                     valid_in[hit_idx] = 1'b0;
                     held_in = held_ff - 1'b1;
                     o_ok_in = 1'b1;
                     o_status_in = ST_REMOVED;
                  end else begin
                     o_status_in = ST_NOT_FOUND;
                  end
               end
               FUNC_CONTAINS: begin
                  o_ok_in = hit_any;
                  o_status_in = hit_any ? ST_PRESENT : ST_ABSENT;
               end
               default: begin
                  o_status_in = ST_ABSENT;
               end
            endcase
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         valid_ff <= '0;
         next_seq_ff <= '0;
         held_ff <= '0;
         o_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         next_seq_ff <= next_seq_in;
         held_ff <= held_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      scan_ff <= scan_in;
      best_v_ff <= best_v_in;
      best_ff <= best_in;
      best_prio_ff <= best_prio_in;
      best_seq_ff <= best_seq_in;
      o_ok_ff <= o_ok_in;
      o_status_ff <= o_status_in;
      o_id_ff <= o_id_in;
      o_prio_ff <= o_prio_in;
      o_seq_ff <= o_seq_in;
      o_pay_ff <= o_pay_in;
      if (wr_en) begin
         id_ff[wr_idx] <= cur_ff.task_id;
         prio_ff[wr_idx] <= cur_ff.prio;
         seq_ff[wr_idx] <= next_seq_ff;
         pay_ff[wr_idx] <= cur_ff.payload;
      end
   end

   // the response register keeps the request alive until it is shown
   assign back_busy = (state_ff != BK_IDLE) || o_valid_ff;
   assign rsp_valid = o_valid_ff;
   assign rsp_ok = o_ok_ff;
   assign rsp_status = o_status_ff;
   assign rsp_out_id = o_id_ff;
   assign rsp_out_prio = o_prio_ff;
   assign rsp_out_seq = o_seq_ff;
   assign rsp_out_payload = o_pay_ff;
   assign rsp_count = COUNT_W'(held_ff);
   assign rsp_is_empty = held_ff == '0;

endmodule

FILE: rtl/priority_fifo_queue_with_dedup.sv
// top level of the stable priority queue with duplicate id rejection
//
//   channel   ports                                    handshake
//   request   req_func req_task_id req_prio req_payload start & !busy
//   response  rsp_ok rsp_status rsp_out_* rsp_count..  rsp_valid, one cycle
//
// enqueue, remove and contains pass from the front queue through the idle and done states
// to the response register; pop also scans every slot, one slot a cycle, for the best entry.
// busy stays high until the response has been shown; next request the cycle after.
// synchronous reset empties the queue and clears the sequence counter.
// the response cannot be stalled.
module priority_fifo_queue_with_dedup import pfq_pkg::*; #(
   parameter int DEPTH   = 16,
   parameter int ID_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_func,
   input  logic [TASK_ID_W-1:0]     req_task_id,
   input  logic signed [PRIO_W-1:0] req_prio,
   input  logic [PAYLOAD_W-1:0]     req_payload,
   output logic                     rsp_valid,
   output logic                     rsp_ok,
   output logic [3:0]               rsp_status,
   output logic [TASK_ID_W-1:0]     rsp_out_id,
   output logic signed [PRIO_W-1:0] rsp_out_prio,
   output logic [SEQ_W-1:0]         rsp_out_seq,
   output logic [PAYLOAD_W-1:0]     rsp_out_payload,
   output logic [COUNT_W-1:0]       rsp_count,
   output logic                     rsp_is_empty
);

   logic    q_valid, q_pop, back_busy;
   req_type q_data;

   pfq_front #(.ID_BITS(ID_BITS)) u_front (
      .clock, .reset, .start, .busy, .req_func, .req_task_id, .req_prio,
      .req_payload, .q_valid, .q_data, .q_pop, .back_busy
   );

   pfq_back #(.DEPTH(DEPTH)) u_back (
      .clock, .reset, .q_valid, .q_data, .q_pop, .back_busy, .rsp_valid,
      .rsp_ok, .rsp_status, .rsp_out_id, .rsp_out_prio, .rsp_out_seq,
      .rsp_out_payload, .rsp_count, .rsp_is_empty
   );

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_single_response: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response shown twice");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_is_empty == (rsp_count == '0))
      else $error("empty flag disagrees with count");

   a_ok_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ok) |-> (rsp_status == ST_QUEUED || rsp_status == ST_DISPATCHED ||
         rsp_status == ST_REMOVED || rsp_status == ST_PRESENT))
      else $error("ok with a failure status");

endmodule

FILE: bench/testbench.sv
// self-checking testbench for the priority queue with duplicate id rejection
module testbench;
   import pfq_pkg::*;

   localparam int DEPTH = 16;
   localparam int RANDOM_REQUESTS = 400;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      logic                     ok;
      status_type               status;
      logic [TASK_ID_W-1:0]     id;
      logic signed [PRIO_W-1:0] prio;
      logic [SEQ_W-1:0]         seq;
      logic [PAYLOAD_W-1:0]     payload;
      logic [COUNT_W-1:0]       count;
      logic                     is_empty;
   } response_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [1:0]               req_func = 2'd0;
   logic [TASK_ID_W-1:0]     req_task_id = '0;
   logic signed [PRIO_W-1:0] req_prio = '0;
   logic [PAYLOAD_W-1:0]     req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ok;
   logic [3:0]               rsp_status;
   logic [TASK_ID_W-1:0]     rsp_out_id;
   logic signed [PRIO_W-1:0] rsp_out_prio;
   logic [SEQ_W-1:0]         rsp_out_seq;
   logic [PAYLOAD_W-1:0]     rsp_out_payload;
   logic [COUNT_W-1:0]       rsp_count;
   logic                     rsp_is_empty;

   // shadow copy of the queue contents
   logic                     slot_valid [DEPTH];
   logic [TASK_ID_W-1:0]     slot_id [DEPTH];
   logic signed [PRIO_W-1:0] slot_prio [DEPTH];
   logic [SEQ_W-1:0]         slot_seq [DEPTH];
   logic [PAYLOAD_W-1:0]     slot_payload [DEPTH];
   logic [SEQ_W-1:0]         seq_counter;

   response_type             pending_responses [$];
   logic [TASK_ID_W-1:0]     id_pool [24];
   int                       error_count = 0;
   int                       cycle_count = 0;
   int                       sender_idle_pct = 0;

   priority_fifo_queue_with_dedup #(.DEPTH(DEPTH), .ID_BITS(16)) u_dut (.*);

   always #6 clock = ~clock;

   function automatic int find_slot(logic [TASK_ID_W-1:0] id);
      for (int i = 0; i < DEPTH; i++)
         if (slot_valid[i] && slot_id[i] == id) return i;
      return -1;
   endfunction

   function automatic response_type queue_after_request(func_type func,
         logic [TASK_ID_W-1:0] id, logic signed [PRIO_W-1:0] prio,
         logic [PAYLOAD_W-1:0] payload);
      response_type r;
      int slot;
      int held;
      r = '{ok: 1'b0, status: ST_QUEUED, id: '0, prio: '0, seq: '0, payload: '0,
            count: '0, is_empty: 1'b0};
      slot = -1;
      held = 0;
      case (func)
         FUNC_ENQ: begin
            if (find_slot(id) >= 0) begin
               r.status = ST_DUPLICATE;
            end else begin
               for (int i = DEPTH - 1; i >= 0; i--)
                  if (!slot_valid[i]) slot = i;
               if (slot < 0) begin
                  r.status = ST_FULL;
               end else begin
                  slot_valid[slot] = 1'b1;
                  slot_id[slot] = id;
                  slot_prio[slot] = prio;
                  slot_seq[slot] = seq_counter;
                  slot_payload[slot] = payload;
                  seq_counter++;
                  r.ok = 1'b1;
                  r.status = ST_QUEUED;
               end
            end
         end
         FUNC_POP: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (slot_valid[i] && (slot < 0 || slot_prio[i] > slot_prio[slot] ||
                     (slot_prio[i] == slot_prio[slot] && slot_seq[i] < slot_seq[slot])))
                  slot = i;
            end
            if (slot < 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.ok = 1'b1;
               r.status = ST_DISPATCHED;
               r.id = slot_id[slot];
               r.prio = slot_prio[slot];
               r.seq = slot_seq[slot];
               r.payload = slot_payload[slot];
               slot_valid[slot] = 1'b0;
            end
         end
         FUNC_REMOVE: begin
            slot = find_slot(id);
            if (slot < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               slot_valid[slot] = 1'b0;
               r.ok = 1'b1;
               r.status = ST_REMOVED;
            end
         end
         default: begin
            r.ok = find_slot(id) >= 0;
            r.status = r.ok ? ST_PRESENT : ST_ABSENT;
         end
      endcase
      for (int i = 0; i < DEPTH; i++)
         if (slot_valid[i]) held++;
      r.count = held[COUNT_W-1:0];
      r.is_empty = held == 0;
      return r;
   endfunction

   // request stays up after acceptance unless the idle draw lowers start; else the caller lowers start or sends again
   task automatic send_request(func_type func, logic [TASK_ID_W-1:0] id,
         logic signed [PRIO_W-1:0] prio, logic [PAYLOAD_W-1:0] payload);
      response_type predicted;
      start <= 1'b1;
      req_func <= func;
      req_task_id <= id;
      req_prio <= prio;
      req_payload <= payload;
      do @(posedge clock); while (busy);
      predicted = queue_after_request(func, id, prio, payload);
      pending_responses.insert(pending_responses.size(), predicted);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic wait_until_drained();
      start <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(string name, longint expected, longint actual);
      if (expected != actual) begin
         $error("%s expected %0h got %0h", name, expected, actual);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      response_type e;
      if (!reset && rsp_valid) begin
         if (pending_responses.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            e = pending_responses.pop_front();
            check_field("ok", e.ok, rsp_ok);
            check_field("status", e.status, rsp_status);
            check_field("out_id", e.id, rsp_out_id);
            check_field("out_prio", e.prio, rsp_out_prio);
            check_field("out_seq", e.seq, rsp_out_seq);
            check_field("out_payload", e.payload, rsp_out_payload);
            check_field("count", e.count, rsp_count);
            check_field("is_empty", e.is_empty, rsp_is_empty);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic test_empty_queue();
      send_request(FUNC_POP, 16'h0000, 8'sd0, 32'h0);
      send_request(FUNC_CONTAINS, 16'hffff, 8'sd0, 32'h0);
      send_request(FUNC_REMOVE, 16'h1234, 8'sd0, 32'h0);
   endtask

   task automatic test_fill_and_full();
      // equal priorities among the fill check fifo order on pop
      send_request(FUNC_ENQ, 16'h0000, -8'sd128, 32'h0000_0000);
      send_request(FUNC_ENQ, 16'hffff, 8'sd127, 32'hffff_ffff);
      send_request(FUNC_ENQ, 16'hffff, 8'sd5, 32'h1);
      send_request(FUNC_CONTAINS, 16'hffff, 8'sd0, 32'h0);
      for (int i = 2; i < DEPTH; i++)
         send_request(FUNC_ENQ, 16'(i * 16'h1111 + 3), 8'(i % 3), $urandom);
      send_request(FUNC_ENQ, 16'h5a5a, 8'sd1, 32'h2);
      send_request(FUNC_ENQ, 16'h0000, 8'sd1, 32'h3);
      send_request(FUNC_REMOVE, 16'h0000, 8'sd0, 32'h0);
      send_request(FUNC_POP, 16'h0, 8'sd0, 32'h0);
      send_request(FUNC_POP, 16'h0, 8'sd0, 32'h0);
      send_request(FUNC_POP, 16'h0, 8'sd0, 32'h0);
   endtask

   task automatic test_random_mix(int requests);
      int pick;
      logic [TASK_ID_W-1:0] id;
      for (int n = 0; n < requests; n++) begin
         pick = $urandom_range(99);
         id = ($urandom_range(9) < 2) ? TASK_ID_W'($urandom) : id_pool[$urandom_range(23)];
         if (pick < 45) send_request(FUNC_ENQ, id, PRIO_W'($urandom_range(255)), $urandom);
         else if (pick < 72) send_request(FUNC_POP, id, PRIO_W'($urandom), $urandom);
         else if (pick < 86) send_request(FUNC_REMOVE, id, PRIO_W'($urandom), $urandom);
         else send_request(FUNC_CONTAINS, id, PRIO_W'($urandom), $urandom);
      end
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) slot_valid[i] = 1'b0;
      seq_counter = '0;
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hffff;
      for (int i = 2; i < 24; i++) id_pool[i] = TASK_ID_W'($urandom);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_queue();
      test_fill_and_full();
      sender_idle_pct = 21;
      test_random_mix(RANDOM_REQUESTS / 3);
      wait_until_drained();
      sender_idle_pct = 81;
      test_random_mix(RANDOM_REQUESTS / 3);
      wait_until_drained();
      sender_idle_pct = 0;
      test_random_mix(RANDOM_REQUESTS / 3);
      wait_until_drained();
      repeat (DEPTH + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
